// File: sv/fppm_pkg.sv
package fppm_pkg;

  // verdict codes
  typedef enum logic [1:0] {
    VERDICT_NONE     = 2'd0,
    VERDICT_AGREE    = 2'd1,
    VERDICT_DISAGREE = 2'd2
  } verdict_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_FLOOR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAD_POLLS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_ALARM    = 3'd4;

  localparam logic [31:0] STALE_LIMIT_RST  = 32'd60000;
  localparam logic [31:0] SETTLE_TIME_RST  = 32'd90000;
  localparam logic [15:0] TOL_FLOOR_RST    = 16'd40;
  localparam logic [7:0]  BAD_POLLS_RST    = 8'd2;
  localparam logic [7:0]  FAIL_ALARM_RST   = 8'd4;

  localparam logic [7:0]  CNT_MAX          = 8'hff;

  typedef struct packed {
    logic [31:0] stale_limit_ms;
    logic [31:0] settle_time_ms;
    logic [15:0] tolerance_floor_dw;
    logic [7:0]  bad_polls_needed;
    logic [7:0]  fail_alarm_count;
  } cfg_t;

  typedef struct packed {
    logic [31:0]       now_ms;
    logic signed [4:0] fan_speed;
    logic              reading_ok;
    logic [15:0]       power_dw;
  } poll_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        alert_edge;
    logic        decidable;
    logic [8:0]  expected_dw;
    logic        meter_lost;
    logic        meter_resumed;
    logic [15:0] stored_power_dw;
  } judge_t;

  // baseline fan power per table speed, in dW
  function automatic logic [8:0] base_dw(input logic [4:0] idx);
    logic [8:0] val;
    case (idx)
      5'd0:    val = 9'd14;
      5'd1:    val = 9'd37;
      5'd2:    val = 9'd48;
      5'd3:    val = 9'd70;
      5'd4:    val = 9'd76;
      5'd5:    val = 9'd100;
      5'd6:    val = 9'd125;
      5'd7:    val = 9'd158;
      5'd8:    val = 9'd197;
      5'd9:    val = 9'd250;
      5'd10:   val = 9'd302;
      5'd11:   val = 9'd377;
      default: val = 9'd442;
    endcase
    return val;
  endfunction

endpackage

// File: sv/fan_power_plausibility_monitor_unit.sv
// Fan power plausibility monitor: one request per poll (time, commanded fan
// speed, read status, power in dW), one result per request. A poll is taken
// every cycle when the result side keeps up; each request passes through the
// input register and then the result register, with the whole judgment
// (read tracking, speed settle, freshness, band check, verdict, nearest table
// speed) done in one pass of shallow logic between them. The poll state
// updates as a request leaves the input register, so back-to-back polls see
// each other's effects. The user writes configuration via cfg_we/cfg_index/
// cfg_wdata only while idle (not enforced); unknown indexes are ignored.
module fan_power_plausibility_monitor_unit #(
  parameter int TABLE_SPEEDS = 13,
  parameter int TIME_BITS    = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [fppm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  // poll requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   in_now_ms,
  input  logic signed [4:0]             in_fan_speed,
  input  logic                          in_reading_ok,
  input  logic [15:0]                   in_power_dw,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_verdict,
  output logic                          out_alert_edge,
  output logic                          out_decidable,
  output logic [8:0]                    out_expected_dw,
  output logic [3:0]                    out_nearest_table_speed,
  output logic                          out_meter_lost,
  output logic                          out_meter_resumed
);

  fppm_pkg::cfg_t   cfg_r;
  fppm_pkg::poll_t  poll_r;
  fppm_pkg::judge_t judge;
  logic             in_v_r;
  logic             out_v_r;
  logic             advance;
  logic [3:0]       nearest;

  logic [1:0]       verdict_r;
  logic             alert_r, decidable_r, lost_r, resumed_r;
  logic [8:0]       expected_r;
  logic [3:0]       nearest_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stale_limit_ms     <= fppm_pkg::STALE_LIMIT_RST;
      cfg_r.settle_time_ms     <= fppm_pkg::SETTLE_TIME_RST;
      cfg_r.tolerance_floor_dw <= fppm_pkg::TOL_FLOOR_RST;
      cfg_r.bad_polls_needed   <= fppm_pkg::BAD_POLLS_RST;
      cfg_r.fail_alarm_count   <= fppm_pkg::FAIL_ALARM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fppm_pkg::REG_STALE_LIMIT: cfg_r.stale_limit_ms     <= cfg_wdata;
        fppm_pkg::REG_SETTLE_TIME: cfg_r.settle_time_ms     <= cfg_wdata;
        fppm_pkg::REG_TOL_FLOOR:   cfg_r.tolerance_floor_dw <= cfg_wdata[15:0];
        fppm_pkg::REG_BAD_POLLS:   cfg_r.bad_polls_needed   <= cfg_wdata[7:0];
        fppm_pkg::REG_FAIL_ALARM:  cfg_r.fail_alarm_count   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // request moves to the result register when that register is free or drains
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll_r.now_ms     <= in_now_ms;
      poll_r.fan_speed  <= in_fan_speed;
      poll_r.reading_ok <= in_reading_ok;
      poll_r.power_dw   <= in_power_dw;
    end
  end

  // poll state and judgment
  fppm_judge #(
    .TABLE_SPEEDS (TABLE_SPEEDS),
    .TIME_BITS    (TIME_BITS)
  ) u_judge (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .poll    (poll_r),
    .cfg     (cfg_r),
    .res     (judge)
  );

  // nearest table speed for the reading held after this poll
  fppm_nearest #(
    .TABLE_SPEEDS (TABLE_SPEEDS)
  ) u_nearest (
    .power_dw    (judge.stored_power_dw),
    .closest_spd (nearest)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict_r   <= judge.verdict;
      alert_r     <= judge.alert_edge;
      decidable_r <= judge.decidable;
      expected_r  <= judge.expected_dw;
      nearest_r   <= nearest;
      lost_r      <= judge.meter_lost;
      resumed_r   <= judge.meter_resumed;
    end
  end

  assign out_valid               = out_v_r;
  assign out_verdict             = verdict_r;
  assign out_alert_edge          = alert_r;
  assign out_decidable           = decidable_r;
  assign out_expected_dw         = expected_r;
  assign out_nearest_table_speed = nearest_r;
  assign out_meter_lost          = lost_r;
  assign out_meter_resumed       = resumed_r;

  // a poll that cannot be judged always reports cannot say
  a_undecidable_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_decidable) |-> (out_verdict == fppm_pkg::VERDICT_NONE))
    else $error("undecidable poll with a verdict");

  // agreement needs a judged poll
  a_agree_decidable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_verdict == fppm_pkg::VERDICT_AGREE)) |-> out_decidable)
    else $error("agree verdict on undecidable poll");

  // lost comes from a failed read, resumed from a good one
  a_lost_resumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_meter_lost && out_meter_resumed))
    else $error("meter lost and resumed together");

  // a finished result is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |-> !advance)
    else $error("result register overwritten");

endmodule

// File: sv/fppm_nearest.sv
module fppm_nearest #(
  parameter int TABLE_SPEEDS = 13
) (
  input  logic [15:0] power_dw,
  output logic [3:0]  closest_spd
);

  localparam int NW = $clog2(TABLE_SPEEDS);

  // table is sorted, so the nearest entry is the number of distinct-step
  // midpoints strictly below the reading (ties go to the lower index)
  logic [NW-1:0] cnt;
  logic [NW+3:0] cnt_ext;
  logic [16:0]   p2;

  assign p2 = {power_dw, 1'b0};

  always_comb begin
    logic [8:0] lo;
    logic [8:0] hi;
    cnt = '0;
    for (int i = 1; i < TABLE_SPEEDS; i++) begin
      lo = fppm_pkg::base_dw(5'(i - 1));
      hi = fppm_pkg::base_dw(5'(i));
      if ((hi != lo) && (p2 > (17'(lo) + 17'(hi)))) begin
        cnt = cnt + NW'(1);
      end
    end
  end

  assign cnt_ext     = (NW + 4)'(cnt);
  assign closest_spd = cnt_ext[3:0];

endmodule

// File: sv/fppm_judge.sv
module fppm_judge #(
  parameter int TABLE_SPEEDS = 13,
  parameter int TIME_BITS    = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  fppm_pkg::poll_t   poll,
  input  fppm_pkg::cfg_t    cfg,
  output fppm_pkg::judge_t  res
);

  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic                  seen_valid_r, seen_valid_nxt;
  logic [4:0]            seen_r, seen_nxt;
  logic [TIME_BITS-1:0]  since_r, since_nxt;
  logic [15:0]           stored_r, stored_nxt;
  logic [TIME_BITS-1:0]  rtime_r, rtime_nxt;
  logic                  ever_r, ever_nxt;
  logic [7:0]            streak_r, streak_nxt;
  fppm_pkg::verdict_t    verdict_r, verdict_nxt;
  logic [7:0]            failed_r, failed_nxt;

  logic [CW-1:0]         now_ext;
  logic [TIME_BITS-1:0]  now;
  logic [4:0]            sraw;
  logic                  new_speed;
  logic [7:0]            streak_eff;
  logic [TIME_BITS-1:0]  age, held;
  logic                  fresh, settled, spd_listed, decidable;
  logic [8:0]            expected;
  logic [15:0]           gap_dw;
  logic [16:0]           tol2;
  logic                  in_band;
  logic                  lost_flag, resumed_flag, alert_flag;

  assign now_ext = CW'(poll.now_ms);
  assign now     = now_ext[TIME_BITS-1:0];
  assign sraw    = poll.fan_speed;

  // read first
  always_comb begin
    lost_flag    = 1'b0;
    resumed_flag = 1'b0;
    failed_nxt   = failed_r;
    stored_nxt   = stored_r;
    rtime_nxt    = rtime_r;
    ever_nxt     = ever_r;
    if (poll.reading_ok) begin
      resumed_flag = (failed_r >= cfg.fail_alarm_count);
      failed_nxt   = '0;
      stored_nxt   = poll.power_dw;
      rtime_nxt    = now;
      ever_nxt     = 1'b1;
    end else if (failed_r != fppm_pkg::CNT_MAX) begin
      failed_nxt = failed_r + 8'd1;
      lost_flag  = (failed_nxt == cfg.fail_alarm_count);
    end
  end

  // speed tracking
  assign new_speed      = !seen_valid_r || (sraw != seen_r);
  assign seen_valid_nxt = 1'b1;
  assign seen_nxt       = sraw;
  assign since_nxt      = new_speed ? now : since_r;
  assign streak_eff     = new_speed ? 8'd0 : streak_r;

  assign age        = now - rtime_nxt;
  assign held       = now - since_nxt;
  assign fresh      = ever_nxt && (CW'(age) <= CW'(cfg.stale_limit_ms));
  assign settled    = CW'(held) >= CW'(cfg.settle_time_ms);
  assign spd_listed = !sraw[4] && (32'(sraw[3:0]) < 32'(TABLE_SPEEDS));
  assign decidable  = fresh && settled && spd_listed;
  assign expected   = spd_listed ? fppm_pkg::base_dw({1'b0, sraw[3:0]}) : 9'd0;

  assign gap_dw  = (stored_nxt > 16'(expected)) ? (stored_nxt - 16'(expected))
                                                : (16'(expected) - stored_nxt);
  assign tol2    = (17'(expected) > {cfg.tolerance_floor_dw, 1'b0}) ?
                   17'(expected) : {cfg.tolerance_floor_dw, 1'b0};
  assign in_band = {gap_dw, 1'b0} <= tol2;

  always_comb begin
    streak_nxt  = streak_eff;
    verdict_nxt = fppm_pkg::VERDICT_NONE;
    alert_flag  = 1'b0;
    if (!decidable) begin
      alert_flag = (verdict_r == fppm_pkg::VERDICT_DISAGREE);
    end else begin
      if (in_band) begin
        streak_nxt  = '0;
        verdict_nxt = fppm_pkg::VERDICT_AGREE;
      end else begin
        if (streak_eff != fppm_pkg::CNT_MAX) begin
          streak_nxt = streak_eff + 8'd1;
        end
        verdict_nxt = (streak_nxt >= cfg.bad_polls_needed) ?
                      fppm_pkg::VERDICT_DISAGREE : verdict_r;
      end
      alert_flag =
        ((verdict_nxt == fppm_pkg::VERDICT_DISAGREE) &&
         (verdict_r != fppm_pkg::VERDICT_DISAGREE)) ||
        ((verdict_nxt == fppm_pkg::VERDICT_AGREE) &&
         (verdict_r == fppm_pkg::VERDICT_DISAGREE));
    end
  end

  assign res.verdict         = verdict_nxt;
  assign res.alert_edge      = alert_flag;
  assign res.decidable       = decidable;
  assign res.expected_dw     = expected;
  assign res.meter_lost      = lost_flag;
  assign res.meter_resumed   = resumed_flag;
  assign res.stored_power_dw = stored_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_valid_r <= 1'b0;
      seen_r       <= '0;
      since_r      <= '0;
      stored_r     <= '0;
      rtime_r      <= '0;
      ever_r       <= 1'b0;
      streak_r     <= '0;
      verdict_r    <= fppm_pkg::VERDICT_NONE;
      failed_r     <= '0;
    end else if (advance) begin
      seen_valid_r <= seen_valid_nxt;
      seen_r       <= seen_nxt;
      since_r      <= since_nxt;
      stored_r     <= stored_nxt;
      rtime_r      <= rtime_nxt;
      ever_r       <= ever_nxt;
      streak_r     <= streak_nxt;
      verdict_r    <= verdict_nxt;
      failed_r     <= failed_nxt;
    end
  end

endmodule
